[src/pwl_pkg.sv]
// ============================================================================
// pwl_pkg: shared types and constants for the piecewise-linear table
// Field widths, command and status codes, sequencer states, table entry.
// ============================================================================
package pwl_pkg;

    localparam int PIDX_W         = 7;    // point_index width
    localparam int OFF_W          = 16;   // breakpoint / query offset width
    localparam int VAL_W          = 16;   // Q0.16 value width
    localparam int CNT_CFG_W      = 8;    // point_count register width
    localparam int STAT_W         = 2;    // status width
    localparam int PROD_W         = 32;   // |dv| * dq magnitude width
    localparam int MAX_POINTS_DEF = 128;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } pwl_cmd_t;

    typedef enum logic [STAT_W-1:0]
    {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_LOADED = 2'd2
    } pwl_status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_DIVGO,
        S_DIVWAIT,
        S_FINISH
    } pwl_state_t;

    // one breakpoint as stored in the table memory
    typedef struct packed
    {
        logic [OFF_W-1:0] offset;
        logic [VAL_W-1:0] value;
    } pwl_point_t;

endpackage

[src/pwl_if.sv]
// ============================================================================
// pwl_if: valid/ready channels of the piecewise-linear table
// Request channel (load or query) and response channel (value, status).
// ============================================================================
interface pwl_in_if import pwl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [PIDX_W-1:0] point_index;
    logic [OFF_W-1:0]  point_offset;
    logic [VAL_W-1:0]  point_value;
    logic [OFF_W-1:0]  query_offset;

    modport source (output valid, command, point_index, point_offset, point_value,
                    query_offset, input ready);
    modport sink   (input valid, command, point_index, point_offset, point_value,
                    query_offset, output ready);
endinterface

interface pwl_out_if import pwl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  result_value;
    logic [STAT_W-1:0] status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

[src/pwl_table.sv]
// ============================================================================
// pwl_table: breakpoint memory
// One write port, one read port, registered read data.
// ============================================================================
module pwl_table import pwl_pkg::*;
#(
    parameter int DEPTH  = MAX_POINTS_DEF,
    parameter int ADDR_W = $clog2(MAX_POINTS_DEF)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pwl_point_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pwl_point_t        rd_data
);

    pwl_point_t mem [DEPTH];
    pwl_point_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/pwl_div.sv]
// ============================================================================
// pwl_div: unsigned restoring divider
// 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// ============================================================================
module pwl_div import pwl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [OFF_W-1:0]  divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic [OFF_W-1:0]  rem_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [OFF_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;

    logic [OFF_W:0]    trial;
    logic              ge;
    logic [OFF_W:0]    diff;

    // one restoring step: shift in the next dividend bit, try subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[PROD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == STEP_W'(1));
            if (start)
            begin
                cnt_reg <= STEP_W'(PROD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/piecewise_linear_table_interp.sv]
// ============================================================================
// piecewise_linear_table_interp: breakpoint table with linear interpolation
// Loads breakpoints by slot and interpolates Q0.16 values at query offsets.
// ============================================================================
// Usage:
//   req (valid/ready) carries one word: a load (command 0) writes point_offset
//   and point_value into slot point_index; a query (command 1) interpolates at
//   query_offset over the first point_count slots (capped at MAX_POINTS).
//   rsp (valid/ready) returns exactly one word per request: result_value and
//   status (0 ok, 1 out of range, 2 load accepted).
//   cfg_wr_en / cfg_wr_data write point_count; write it only while idle.
// Timing:
//   One request is in flight at a time. A load goes from accept straight to
//   the response register. A query walks the table at one slot per cycle
//   through the single read port of the table memory, then passes through
//   the multiply and the 32-step restoring divider before its result is
//   registered; the next request is taken once the response is loaded.
// Reset: rst_n clears control state and point_count; the table holds no reset
//   and a slot must be loaded before a query reads it.
// Stall: the response sits in an output register; the next request is taken
//   while it waits, and its result waits in turn until rsp.ready.
// ============================================================================
module piecewise_linear_table_interp import pwl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CNT_CFG_W-1:0] cfg_wr_data,
    pwl_in_if.sink               req,
    pwl_out_if.source            rsp
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CMP_W  = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
    localparam int SLOT_W = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;

    pwl_state_t           state_reg, state_next;
    logic [CNT_CFG_W-1:0] point_count_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 pend_reg;
    logic                 have_lo_reg;
    logic [OFF_W-1:0]     q_reg;
    logic [OFF_W-1:0]     lo_off_reg, hi_off_reg;
    logic [VAL_W-1:0]     lo_val_reg, hi_val_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [OFF_W-1:0]     dvs_reg;
    logic [VAL_W-1:0]     res_val_reg;
    pwl_status_t          res_st_reg;
    logic                 out_valid_reg;
    logic [VAL_W-1:0]     out_val_reg;
    pwl_status_t          out_st_reg;

    pwl_point_t           rd_data;
    pwl_point_t           wr_data;
    logic                 rd_en, wr_en, div_start, div_done, out_load, accept;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [PROD_W-1:0]    div_quo;
    logic                 t_eq, t_lo, t_hi, walk_end, slot_ok;
    logic [CMP_W-1:0]     cnt_ext;
    logic [CNT_W-1:0]     n_cap;
    logic [VAL_W-1:0]     dv_mag;
    logic [OFF_W-1:0]     dq;
    logic [VAL_W+1:0]     sum;
    logic [VAL_W-1:0]     interp;

    // table memory and divider
    pwl_table #(.DEPTH(MAX_POINTS), .ADDR_W(IDX_W)) u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pwl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // search limit and load slot range
    always_comb
    begin
        cnt_ext = CMP_W'(point_count_reg);
        n_cap   = (cnt_ext > CMP_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(cnt_ext);
        slot_ok = (SLOT_W'(req.point_index) < SLOT_W'(MAX_POINTS));
    end

    // compare of the slot read last cycle against the query
    always_comb
    begin
        t_eq     = pend_reg && (rd_data.offset == q_reg);
        t_lo     = pend_reg && (rd_data.offset < q_reg);
        t_hi     = pend_reg && (rd_data.offset > q_reg);
        walk_end = !pend_reg && (issue_reg == n_reg);
    end

    // slope magnitude and offset into the segment
    always_comb
    begin
        dv_mag = (hi_val_reg < lo_val_reg) ? (lo_val_reg - hi_val_reg)
                                           : (hi_val_reg - lo_val_reg);
        dq     = q_reg - lo_off_reg;
    end

    // v1 +/- quotient, saturated to 0 .. 65535
    always_comb
    begin
        if (neg_reg)
        begin
            sum = {2'b00, lo_val_reg} - {2'b00, div_quo[VAL_W-1:0]};
        end
        else
        begin
            sum = {2'b00, lo_val_reg} + {2'b00, div_quo[VAL_W-1:0]};
        end
        if (sum[VAL_W+1])
        begin
            interp = '0;
        end
        else if (sum[VAL_W])
        begin
            interp = '1;
        end
        else
        begin
            interp = sum[VAL_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.command == CMD_LOAD) ? S_FINISH : S_WALK;
                end
            end
            S_WALK:
            begin
                if (t_eq)
                begin
                    state_next = S_FINISH;
                end
                else if (t_hi)
                begin
                    state_next = have_lo_reg ? S_MUL : S_FINISH;
                end
                else if (walk_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL:     state_next = S_DIVGO;
            S_DIVGO:   state_next = S_DIVWAIT;
            S_DIVWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready = (state_reg == S_IDLE);
        accept    = (state_reg == S_IDLE) && req.valid;
        wr_en     = accept && (req.command == CMD_LOAD) && slot_ok;
        wr_addr   = IDX_W'(req.point_index);
        wr_data   = '{offset: req.point_offset, value: req.point_value};
        rd_en     = (state_reg == S_WALK) && (issue_reg < n_reg);
        rd_addr   = issue_reg[IDX_W-1:0];
        div_start = (state_reg == S_DIVGO);
        out_load  = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            issue_reg       <= '0;
            pend_reg        <= 1'b0;
            have_lo_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                point_count_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                issue_reg   <= '0;
                pend_reg    <= 1'b0;
                have_lo_reg <= 1'b0;
            end
            else if (state_reg == S_WALK)
            begin
                pend_reg <= rd_en;
                if (rd_en)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (t_lo)
                begin
                    have_lo_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg       <= req.query_offset;
            n_reg       <= n_cap;
            res_val_reg <= '0;
            res_st_reg  <= STAT_LOADED;
        end
        if (state_reg == S_WALK)
        begin
            if (t_lo)
            begin
                lo_off_reg <= rd_data.offset;
                lo_val_reg <= rd_data.value;
            end
            if (t_hi)
            begin
                hi_off_reg <= rd_data.offset;
                hi_val_reg <= rd_data.value;
            end
            if (t_eq)
            begin
                res_val_reg <= rd_data.value;
                res_st_reg  <= STAT_OK;
            end
            else if ((t_hi && !have_lo_reg) || walk_end)
            begin
                res_val_reg <= '0;
                res_st_reg  <= STAT_RANGE;
            end
        end
        // exact product |v2 - v1| * (q - t1), sign kept apart
        if (state_reg == S_MUL)
        begin
            neg_reg  <= (hi_val_reg < lo_val_reg);
            prod_reg <= PROD_W'(dv_mag) * PROD_W'(dq);
            dvs_reg  <= hi_off_reg - lo_off_reg;
        end
        if ((state_reg == S_DIVWAIT) && div_done)
        begin
            res_val_reg <= interp;
            res_st_reg  <= STAT_OK;
        end
        if (out_load)
        begin
            out_val_reg <= res_val_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_val_reg;
    assign rsp.status       = out_st_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVWAIT))
        else $error("divider finished outside the wait state");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (issue_reg <= n_reg))
        else $error("walk read past the search limit");

    a_load_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.command == CMD_LOAD)) |=> (state_reg == S_FINISH))
        else $error("load did not go straight to the response");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVGO) |-> (dvs_reg != '0))
        else $error("zero segment width at divide start");

    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_quo[PROD_W-1:VAL_W] == '0))
        else $error("interpolation quotient wider than a value");

endmodule

[tb/tb_piecewise_linear_table_interp.sv]
// ============================================================================
// tb_piecewise_linear_table_interp: self-checking bench for the PWL table
// Loads breakpoint tables through the request channel, queries them at
// exact, neighboring, in-between and random offsets, and checks every
// response word against an in-bench interpolation model. Both channels see
// random gaps, and the response side is held off for long stretches.
// ============================================================================
module tb_piecewise_linear_table_interp import pwl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS     = MAX_POINTS_DEF;
    localparam int HOLD_CYCLES = 600;
    localparam int N_PHASES    = 15;

    // one request word and one response word
    typedef struct {
        pwl_cmd_t          cmd;
        logic [PIDX_W-1:0] idx;
        logic [OFF_W-1:0]  off;
        logic [VAL_W-1:0]  val;
        logic [OFF_W-1:0]  qoff;
    } pwl_word_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        pwl_status_t      status;
    } pwl_answer_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CNT_CFG_W-1:0] cfg_wr_data;

    pwl_in_if  req_if ();
    pwl_out_if rsp_if ();

    piecewise_linear_table_interp #(
        .MAX_POINTS (MAX_PTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if)
    );

    always #5 clk = ~clk;

    // model of the table, updated on accepted words, and of point_count
    logic [OFF_W-1:0] mdl_off [MAX_PTS];
    logic [VAL_W-1:0] mdl_val [MAX_PTS];
    int unsigned      mdl_count;

    // stimulus-side copy of the offsets, used to aim queries
    logic [OFF_W-1:0] gen_off [MAX_PTS];

    pwl_word_t   words_to_send [$];
    pwl_answer_t answers_due [$];

    pwl_word_t   word_on_bus;
    int unsigned words_in;
    int          send_gap;
    int          recv_gap;
    int          hold_left;
    int          hold_idx;
    int          err_count = 0;
    bit          gaps_on = 1'b1;

    // interpolation model: applies a load or answers a query
    function automatic pwl_answer_t interp_predict(pwl_word_t w);
        pwl_answer_t a;
        int unsigned n;
        bit          have_lo;
        bit          have_hi;
        bit          hit;
        int          lo;
        int          hi;
        longint      t1;
        longint      t2;
        longint      v1;
        longint      v2;
        longint      q;
        longint      res;
        a.value = '0;
        a.status = STAT_LOADED;
        if (w.cmd == CMD_LOAD)
        begin
            mdl_off[w.idx] = w.off;
            mdl_val[w.idx] = w.val;
            return a;
        end
        n = (mdl_count > MAX_PTS) ? MAX_PTS : mdl_count;
        have_lo = 1'b0;
        have_hi = 1'b0;
        hit = 1'b0;
        lo = 0;
        hi = 0;
        // walk in slot order; stop at first equal or first higher slot
        for (int i = 0; i < int'(n) && !hit && !have_hi; i++)
        begin
            if (mdl_off[i] == w.qoff)
            begin
                hit = 1'b1;
                a.value = mdl_val[i];
            end
            else if (mdl_off[i] < w.qoff)
            begin
                lo = i;
                have_lo = 1'b1;
            end
            else
            begin
                hi = i;
                have_hi = 1'b1;
            end
        end
        if (hit)
        begin
            a.status = STAT_OK;
            return a;
        end
        if (!have_lo || !have_hi)
        begin
            a.status = STAT_RANGE;
            return a;
        end
        t1 = {48'd0, mdl_off[lo]};
        t2 = {48'd0, mdl_off[hi]};
        v1 = {48'd0, mdl_val[lo]};
        v2 = {48'd0, mdl_val[hi]};
        q  = {48'd0, w.qoff};
        // exact product, signed division truncating toward zero
        res = v1 + ((v2 - v1) * (q - t1)) / (t2 - t1);
        if (res < 0)
            res = 0;
        if (res > 65535)
            res = 65535;
        a.value = res[VAL_W-1:0];
        a.status = STAT_OK;
        return a;
    endfunction

    // mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] draw_value();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic flag_error(string msg);
        if (err_count < 10)
            $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic push_load(int idx, int off, int val);
        pwl_word_t w;
        w.cmd  = CMD_LOAD;
        w.idx  = PIDX_W'(idx);
        w.off  = OFF_W'(off);
        w.val  = VAL_W'(val);
        w.qoff = OFF_W'($urandom_range(0, 65535));
        gen_off[idx] = OFF_W'(off);
        words_to_send.push_back(w);
    endtask

    task automatic push_query(int q);
        pwl_word_t w;
        w.cmd  = CMD_QUERY;
        w.idx  = PIDX_W'($urandom_range(0, 127));
        w.off  = OFF_W'($urandom_range(0, 65535));
        w.val  = VAL_W'($urandom_range(0, 65535));
        w.qoff = OFF_W'(q);
        words_to_send.push_back(w);
    endtask

    // sender pauses until every expected response has come back
    task automatic wait_drained();
        while (words_to_send.size() != 0 || req_if.valid || answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_count(int val);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_CFG_W'(val);
        mdl_count = val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // request driver: predicts on accept, then offers the next word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid        <= 1'b0;
            req_if.command      <= CMD_LOAD;
            req_if.point_index  <= '0;
            req_if.point_offset <= '0;
            req_if.point_value  <= '0;
            req_if.query_offset <= '0;
            words_in            <= 0;
            send_gap = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                answers_due.push_back(interp_predict(word_on_bus));
                words_in <= words_in + 1;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    word_on_bus = words_to_send.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.command      <= word_on_bus.cmd;
                    req_if.point_index  <= word_on_bus.idx;
                    req_if.point_offset <= word_on_bus.off;
                    req_if.point_value  <= word_on_bus.val;
                    req_if.query_offset <= word_on_bus.qoff;
                    send_gap = pick_gap();
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // long response hold-off while requests are still pending
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_idx  <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_idx < 2 && words_to_send.size() > 8 &&
                 words_in >= ((hold_idx == 0) ? 420 : 1350))
        begin
            hold_left <= HOLD_CYCLES;
            hold_idx  <= hold_idx + 1;
        end
    end

    // response monitor: checks each word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        pwl_answer_t exp_word;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (answers_due.size() == 0)
                    flag_error($sformatf("unexpected word: value %h status %0d",
                                         rsp_if.result_value, rsp_if.status));
                else
                begin
                    exp_word = answers_due.pop_front();
                    if (rsp_if.result_value !== exp_word.value ||
                        rsp_if.status !== exp_word.status)
                        flag_error($sformatf(
                            "exp value %h status %0d, got value %h status %0d",
                            exp_word.value, exp_word.status,
                            rsp_if.result_value, rsp_if.status));
                end
                recv_gap = pick_gap();
            end
            if (hold_left != 0)
                rsp_if.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin : stim
        int phase_counts [N_PHASES];
        int n;
        int span;
        int off;
        int k;
        int s;
        logic [15:0] q;
        phase_counts = '{2, 1, 6, 128, 3, 255, 12, 0, 40, 129, 4, 200, 2, 9, 128};
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        mdl_count           = 0;
        for (int i = 0; i < MAX_PTS; i++)
            gen_off[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty search after reset
        push_query(16'h0000);
        push_query(16'hFFFF);
        // small table with rising and falling segments, extreme fields
        push_load(0, 16'h0000, 16'h0000);
        push_load(1, 16'h0100, 16'hFFFF);
        push_load(2, 16'h0200, 16'h8000);
        push_load(3, 16'hFFFF, 16'h1234);
        push_load(127, 16'hFFFF, 16'hFFFF);
        set_count(4);
        push_query(16'h0000);
        push_query(16'hFFFF);
        push_query(16'h0080);
        push_query(16'h0101);
        push_query(16'h0200);
        push_query(16'h8000);
        // nothing above the first query; the second falls in a segment
        set_count(3);
        push_query(16'h0300);
        push_query(16'h01FF);
        // nothing below the first query; the second hits slot 0 exactly
        push_load(0, 16'h0010, 16'hFFFF);
        push_query(16'h0005);
        push_query(16'h0010);
        // unsorted table: walk stops at first higher slot
        push_load(2, 16'h0050, 16'h4000);
        push_query(16'h0050);
        push_query(16'h0200);
        set_count(4);
        push_query(16'h0200);
        // duplicate offsets: first equal slot wins
        push_load(1, 16'h0010, 16'h0001);
        push_query(16'h0010);

        // random phases: sorted table per count setting, then mixed traffic
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_count(phase_counts[p]);
            gaps_on = ($urandom_range(0, 3) != 0);
            n = (phase_counts[p] > MAX_PTS) ? MAX_PTS : phase_counts[p];
            if (n > 0)
            begin
                span = 65535 / n;
                off = $urandom_range(0, span);
                for (int i = 0; i < n; i++)
                begin
                    push_load(i, off, draw_value());
                    off += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, span);
                end
            end
            for (int i = 0; i < 80; i++)
            begin
                if ($urandom_range(0, 99) < 22)
                begin
                    if (n > 0 && $urandom_range(0, 9) < 7)
                        k = $urandom_range(0, n - 1);
                    else
                        k = $urandom_range(0, 127);
                    push_load(k, draw_value(), draw_value());
                end
                else if (n == 0)
                    push_query($urandom_range(0, 65535));
                else
                begin
                    k = $urandom_range(0, n - 1);
                    s = $urandom_range(0, 9);
                    if (s < 2)
                        q = gen_off[k];
                    else if (s < 4)
                        q = gen_off[k] + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
                    else if (s < 8)
                        q = 16'($urandom_range(gen_off[k],
                                               gen_off[$urandom_range(0, n - 1)]));
                    else
                        q = 16'($urandom_range(0, 65535));
                    push_query(q);
                end
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (err_count == 0 && answers_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
src/pwl_pkg.sv
src/pwl_if.sv
src/pwl_table.sv
src/pwl_div.sv
src/piecewise_linear_table_interp.sv
tb/tb_piecewise_linear_table_interp.sv
